// ===== design/ptom_pkg.sv =====
// Package for the price-time order matcher: field widths, mode and status codes,
// controller commands. No dependencies.
package ptom_pkg;
   localparam int DefaultDepth = 16;
   localparam int IdW    = 16;
   localparam int PriceW = 24;
   localparam int TimeW  = 32;
   localparam int CountW = 5;

   localparam logic [1:0] MODE_BUY    = 2'd0;
   localparam logic [1:0] MODE_SELL   = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic [2:0] ST_RESTED    = 3'd0;
   localparam logic [2:0] ST_MATCHED   = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_NOTFOUND  = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic load;    // capture request into the request register
      logic update;  // apply the decided shift and build the result
   } cmd_type;

   typedef struct packed {
      logic [2:0] status;
   } stat_type;
endpackage

// ===== design/ptom_ctrl.sv =====
// Controller for the price-time order matcher: accept, decide/update, present result.
// Depends on ptom_pkg.
module ptom_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output ptom_pkg::cmd_type  cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_UPD  = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       take;

   assign take       = req_tvalid && req_tready;
   assign req_tready = !reset &&
                       ((state_ff == S_IDLE) || (state_ff == S_OUT && rsp_tready));
   assign rsp_tvalid = (state_ff == S_OUT);
   assign cmd.load   = take;
   assign cmd.update = (state_ff == S_UPD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (take) state_in = S_UPD;
         S_UPD: state_in = S_OUT;
         S_OUT: begin
            if (take) state_in = S_UPD;
            else if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_upd_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.update) else $error("update missing after load");
   a_out_after_upd: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_tvalid) else $error("result missing after update");
   a_no_load_in_upd: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> !req_tready) else $error("accept during update");
endmodule

// ===== design/ptom_side.sv =====
// One sorted side of the book as a shift register with per-entry compares.
// Depends on ptom_pkg.
module ptom_side #(
   parameter int Depth = ptom_pkg::DefaultDepth,
   parameter bit IsBuy = 1'b1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ptom_pkg::IdW-1:0]     key_id,
   input  logic [ptom_pkg::PriceW-1:0]  key_price,
   input  logic [ptom_pkg::TimeW-1:0]   key_time,
   input  logic                         do_ins,
   input  logic                         do_rm,
   input  logic                         rm_head,
   output logic                         found,
   output logic [ptom_pkg::IdW-1:0]     head_id,
   output logic [ptom_pkg::PriceW-1:0]  head_price,
   output logic [$clog2(Depth+1)-1:0]   count
);
   localparam int CW = $clog2(Depth+1);

   logic [ptom_pkg::IdW-1:0]    id_ff   [Depth];
   logic [ptom_pkg::PriceW-1:0] pr_ff   [Depth];
   logic [ptom_pkg::TimeW-1:0]  tm_ff   [Depth];
   logic [CW-1:0]               cnt_ff;
   logic [Depth-1:0] before_v, hit_v, after_v, first_hit, rm_v, lead_v;

   always_comb begin
      for (int k = 0; k < Depth; k++) begin
         logic valid, worse;
         valid = (k < cnt_ff);
         worse = IsBuy ? (pr_ff[k] < key_price) : (pr_ff[k] > key_price);
         // entries staying ahead of the newcomer
         before_v[k] = valid && !(worse || (pr_ff[k] == key_price && tm_ff[k] >= key_time));
         hit_v[k] = valid && (id_ff[k] == key_id);
      end
      // entry k takes the newcomer when everything below it stays ahead
      lead_v = {before_v[Depth-2:0], 1'b1};
      first_hit = hit_v & ~(hit_v - 1'b1);
      rm_v = rm_head ? {{(Depth-1){1'b0}}, 1'b1} : first_hit;
      // entries at or after the removed one shift towards the head
      after_v = ~((rm_v - 1'b1)) & ~{Depth{1'b0}};
   end

   assign found      = |hit_v;
   assign head_id    = id_ff[0];
   assign head_price = pr_ff[0];
   assign count      = cnt_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < Depth; k++) begin
         if (do_ins && !before_v[k]) begin
            if (lead_v[k]) begin
               id_ff[k] <= key_id; pr_ff[k] <= key_price; tm_ff[k] <= key_time;
            end else begin
               id_ff[k] <= id_ff[(k == 0) ? 0 : k-1];
               pr_ff[k] <= pr_ff[(k == 0) ? 0 : k-1];
               tm_ff[k] <= tm_ff[(k == 0) ? 0 : k-1];
            end
         end else if (do_rm && after_v[k] && k < Depth-1) begin
            id_ff[k] <= id_ff[(k < Depth-1) ? k+1 : k];
            pr_ff[k] <= pr_ff[(k < Depth-1) ? k+1 : k];
            tm_ff[k] <= tm_ff[(k < Depth-1) ? k+1 : k];
         end
      end
      if (reset) cnt_ff <= '0;
      else if (do_ins) cnt_ff <= cnt_ff + 1'b1;
      else if (do_rm) cnt_ff <= cnt_ff - 1'b1;
   end
endmodule

// ===== design/ptom_datapath.sv =====
// Datapath: request register, two book sides, match decision and result register.
// Depends on ptom_pkg and ptom_side.
module ptom_datapath #(
   parameter int Depth = ptom_pkg::DefaultDepth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ptom_pkg::cmd_type           cmd,
   input  logic [1:0]                  mode,
   input  logic [ptom_pkg::IdW-1:0]    order_id,
   input  logic [ptom_pkg::PriceW-1:0] order_price,
   input  logic [ptom_pkg::TimeW-1:0]  order_time,
   output logic [2:0]                  status,
   output logic [ptom_pkg::IdW-1:0]    trade_buy_id,
   output logic [ptom_pkg::IdW-1:0]    trade_sell_id,
   output logic [ptom_pkg::PriceW-1:0] trade_price,
   output logic [4:0]                  buy_count,
   output logic [4:0]                  sell_count
);
   localparam int CW = $clog2(Depth+1);
   localparam logic [CW-1:0] Full = CW'(Depth);

   logic [1:0]                  mode_ff;
   logic [ptom_pkg::IdW-1:0]    id_ff;
   logic [ptom_pkg::PriceW-1:0] pr_ff;
   logic [ptom_pkg::TimeW-1:0]  tm_ff;
   logic [2:0]                  st_ff;
   logic [ptom_pkg::IdW-1:0]    tb_ff, ts_ff;
   logic [ptom_pkg::PriceW-1:0] tp_ff;

   logic b_found, s_found, b_ins, b_rm, s_ins, s_rm, b_rmh, s_rmh;
   logic [ptom_pkg::IdW-1:0]    b_hid, s_hid;
   logic [ptom_pkg::PriceW-1:0] b_hpr, s_hpr;
   logic [CW-1:0]               b_cnt, s_cnt;
   logic buy_cross, sell_cross;
   ptom_pkg::stat_type st;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= mode; id_ff <= order_id; pr_ff <= order_price; tm_ff <= order_time;
      end
   end

   always_comb begin
      buy_cross  = (s_cnt != '0) && (pr_ff >= s_hpr);
      sell_cross = (b_cnt != '0) && (pr_ff <= b_hpr);
      b_ins = 1'b0; b_rm = 1'b0; s_ins = 1'b0; s_rm = 1'b0;
      b_rmh = 1'b0; s_rmh = 1'b0;
      st.status = ptom_pkg::ST_NOTFOUND;
      case (mode_ff)
         ptom_pkg::MODE_BUY: begin
            if (buy_cross) begin st.status = ptom_pkg::ST_MATCHED; s_rm = 1'b1; s_rmh = 1'b1; end
            else if (b_cnt >= Full) st.status = ptom_pkg::ST_FULL;
            else begin st.status = ptom_pkg::ST_RESTED; b_ins = 1'b1; end
         end
         ptom_pkg::MODE_SELL: begin
            if (sell_cross) begin st.status = ptom_pkg::ST_MATCHED; b_rm = 1'b1; b_rmh = 1'b1; end
            else if (s_cnt >= Full) st.status = ptom_pkg::ST_FULL;
            else begin st.status = ptom_pkg::ST_RESTED; s_ins = 1'b1; end
         end
         ptom_pkg::MODE_CANCEL: begin
            if (b_found) begin st.status = ptom_pkg::ST_CANCELLED; b_rm = 1'b1; end
            else if (s_found) begin st.status = ptom_pkg::ST_CANCELLED; s_rm = 1'b1; end
         end
         default: st.status = ptom_pkg::ST_NOTFOUND;
      endcase
   end

   ptom_side #(.Depth(Depth), .IsBuy(1'b1)) u_buy (
      .clock, .reset, .key_id(id_ff), .key_price(pr_ff), .key_time(tm_ff),
      .do_ins(cmd.update && b_ins), .do_rm(cmd.update && b_rm), .rm_head(b_rmh),
      .found(b_found), .head_id(b_hid), .head_price(b_hpr), .count(b_cnt));
   ptom_side #(.Depth(Depth), .IsBuy(1'b0)) u_sell (
      .clock, .reset, .key_id(id_ff), .key_price(pr_ff), .key_time(tm_ff),
      .do_ins(cmd.update && s_ins), .do_rm(cmd.update && s_rm), .rm_head(s_rmh),
      .found(s_found), .head_id(s_hid), .head_price(s_hpr), .count(s_cnt));

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         st_ff <= st.status;
         tb_ff <= '0; ts_ff <= '0; tp_ff <= '0;
         if (st.status == ptom_pkg::ST_MATCHED) begin
            if (mode_ff == ptom_pkg::MODE_BUY) begin
               tb_ff <= id_ff; ts_ff <= s_hid; tp_ff <= s_hpr;
            end else begin
               tb_ff <= b_hid; ts_ff <= id_ff; tp_ff <= b_hpr;
            end
         end
      end
   end

   assign status        = st_ff;
   assign trade_buy_id  = tb_ff;
   assign trade_sell_id = ts_ff;
   assign trade_price   = tp_ff;
   // counts already reflect this item once the result is shown
   assign buy_count  = 5'(b_cnt);
   assign sell_count = 5'(s_cnt);
endmodule

// ===== design/price_time_order_matcher.sv =====
// Top level of the price-time order matcher: controller plus datapath.
// Depends on ptom_pkg, ptom_ctrl, ptom_datapath.
//   channel | direction | contents
//   req     | in        | tdata: mode, order_id, order_price, order_time
//   rsp     | out       | tdata: status, trade_buy_id, trade_sell_id, trade_price, counts
// Each transaction runs through capture, then compare-and-shift of the side
// registers; the result is then held until taken.
// A new request is accepted in the cycle its predecessor's result is taken.
// Synchronous active-high reset empties both sides.
module price_time_order_matcher #(
   parameter int BOOK_DEPTH = ptom_pkg::DefaultDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // mode[1:0] id[17:2] price[41:18] time[73:42]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata   // status, buy id, sell id, price, buy cnt, sell cnt
);
   ptom_pkg::cmd_type cmd;
   logic [2:0]  status;
   logic [15:0] tb, ts;
   logic [23:0] tp;
   logic [4:0]  bc, sc;

   ptom_ctrl u_ctrl (.clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid,
      .rsp_tready, .cmd);

   ptom_datapath #(.Depth(BOOK_DEPTH)) u_dp (.clock, .reset, .cmd,
      .mode(req_tdata[1:0]), .order_id(req_tdata[17:2]),
      .order_price(req_tdata[41:18]), .order_time(req_tdata[73:42]),
      .status, .trade_buy_id(tb), .trade_sell_id(ts), .trade_price(tp),
      .buy_count(bc), .sell_count(sc));

   assign rsp_tdata = {3'd0, sc, bc, tp, ts, tb, status};
endmodule
